// ----- hw/rtl/min_tracking_stack_assert.svh -----
// Assertion macros for the min tracking stack; define ASSERT_OFF to drop them.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check that is ignored while reset is active.
`define MTS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("min_tracking_stack check failed");
// Clocked check that also holds during reset.
`define MTS_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("min_tracking_stack check failed");
`else
`define MTS_ASSERT(label, clk, rst_n, prop)
`define MTS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- hw/rtl/mts_pkg.sv -----
// Shared types and constants of the min tracking stack.
`timescale 1ns / 1ps

package mts_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int ENTRY_W = 34;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic signed [31:0] EMPTY_TOP = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] push_value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic signed [31:0] min_value;
		logic               is_empty;
		logic [1:0]         status;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic wb;
	} ctl_t;

endpackage

// ----- hw/rtl/min_tracking_stack.sv -----
// Top level of the min tracking stack: controller and datapath.
`timescale 1ns / 1ps

// Min tracking stack: a LIFO of signed 32-bit values that reports its minimum.
//
// Command channel: item (operation, push_value) is taken at a rising edge with
// start high and busy low. Operations are push, pop and peek; code 3 acts as peek.
// Result channel: done strobes for exactly one cycle while result carries the
// decoded top, the minimum, the empty flag and the status of that operation.
// The receiver cannot hold results off; result is overwritten at the next write-back.
//
// Timing: the accept edge updates count, minimum and the entry memory, and a pop
// issues a read of the entry below the top. The write-back state (busy high)
// loads that read data and registers the result; done is high in the cycle after.
// The write-back state is there because the entry memory read is registered, and a
// new item may be accepted in the same cycle done is high.
//
// Reset (arst_n low) empties the stack and clears the minimum to zero. The entry
// memory is not cleared; only a pop that empties the stack reads at or above the count.
// Push when full leaves everything unchanged and reports status full; pop or
// peek on an empty stack reports status empty.
`include "min_tracking_stack_assert.svh"

module min_tracking_stack (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mts_pkg::item_t   item,
	output logic             done,
	output mts_pkg::result_t result
);
	import mts_pkg::*;

	ctl_t ctl;

	// Sequence accept and write-back.
	mts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// Hold the stack state and build each result word.
	mts_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item),
		.result (result)
	);

	// An accepted word is followed by the write-back state, then the strobe.
	`MTS_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	`MTS_ASSERT(a_accept_done, clk, arst_n, (start && !busy) |-> ##2 done)
	// A full push can never leave the stack empty; an empty status always does.
	`MTS_ASSERT(a_full_not_empty, clk, arst_n,
		(done && result.status == ST_FULL) |-> !result.is_empty)
	`MTS_ASSERT(a_empty_status, clk, arst_n,
		(done && result.status == ST_EMPTY) |-> result.is_empty)
	// The strobe and busy never overlap.
	`MTS_ASSERT_ALWAYS(a_done_not_busy, clk, !(done && busy))

endmodule

// ----- hw/rtl/mts_ctrl.sv -----
// Controller of the min tracking stack: accept, write-back and strobe sequencing.
`timescale 1ns / 1ps

module mts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output mts_pkg::ctl_t ctl
);
	import mts_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_WB
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_WB;
						busy_q  <= 1'b1;
					end
				end
				S_WB: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign ctl.accept = start && !busy_q;
	assign ctl.wb     = (state_q == S_WB);

endmodule

// ----- hw/rtl/mts_datapath.sv -----
// Datapath of the min tracking stack: entry memory, count, minimum and result register.
`timescale 1ns / 1ps

module mts_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  mts_pkg::ctl_t    ctl,
	input  mts_pkg::item_t   item,
	output mts_pkg::result_t result
);
	import mts_pkg::*;

	logic signed [ENTRY_W-1:0] mem [STACK_DEPTH];

	logic [CNT_W-1:0]          count_q;
	logic signed [31:0]        min_q;
	logic signed [ENTRY_W-1:0] top_q;
	logic signed [ENTRY_W-1:0] rdata_q;
	logic                      pop_ld_q;
	logic [1:0]                status_q;
	result_t                   result_q;

	logic                      is_zero;
	logic                      is_full;
	logic signed [ENTRY_W-1:0] x34;
	logic signed [ENTRY_W-1:0] min34;
	logic                      x_lt_min;
	logic signed [ENTRY_W-1:0] enc;
	logic signed [ENTRY_W-1:0] restore;
	logic                      top_is_code;
	logic                      do_push;
	logic                      do_pop;
	logic [1:0]                new_status;
	logic [ADDR_W-1:0]         wr_addr;
	logic [ADDR_W-1:0]         rd_addr;
	logic [CNT_W-1:0]          below_top;
	logic signed [ENTRY_W-1:0] top_now;
	logic                      top_now_code;

	always_comb begin
		is_zero     = (count_q == '0);
		is_full     = (count_q == CNT_W'(STACK_DEPTH));
		x34         = {{(ENTRY_W - 32){item.push_value[31]}}, item.push_value};
		min34       = {{(ENTRY_W - 32){min_q[31]}}, min_q};
		x_lt_min    = (item.push_value < min_q);
		// A value below the minimum of a non-empty stack is stored as 2*value - min.
		enc         = (x_lt_min && !is_zero) ? (x34 + x34 - min34) : x34;
		restore     = min34 + min34 - top_q;
		top_is_code = (top_q < min34);
		do_push     = ctl.accept && (item.operation == OP_PUSH) && !is_full;
		do_pop      = ctl.accept && (item.operation == OP_POP) && !is_zero;
		wr_addr     = count_q[ADDR_W-1:0];
		below_top   = count_q - CNT_W'(2);
		rd_addr     = below_top[ADDR_W-1:0];
		case (item.operation)
			OP_PUSH: new_status = is_full ? ST_FULL : ST_OK;
			OP_POP:  new_status = is_zero ? ST_EMPTY : ST_OK;
			default: new_status = is_zero ? ST_EMPTY : ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= '0;
		end else begin
			if (do_push) begin
				count_q <= count_q + CNT_W'(1);
				if (is_zero || x_lt_min) begin
					min_q <= item.push_value;
				end
			end else if (do_pop) begin
				count_q <= count_q - CNT_W'(1);
				if (top_is_code) begin
					min_q <= restore[31:0];
				end
			end
		end
	end

	// Entry memory: write on push, registered read of the entry below the top on pop.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_addr] <= enc;
		end
		if (do_pop) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_comb begin
		top_now      = pop_ld_q ? rdata_q : top_q;
		top_now_code = (top_now < min34);
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			pop_ld_q <= do_pop;
			status_q <= new_status;
		end
		if (do_push) begin
			top_q <= enc;
		end else if (ctl.wb && pop_ld_q) begin
			top_q <= rdata_q;
		end
		if (ctl.wb) begin
			result_q.status   <= status_q;
			result_q.is_empty <= is_zero;
			if (is_zero) begin
				result_q.top_value <= EMPTY_TOP;
				result_q.min_value <= '0;
			end else begin
				result_q.top_value <= top_now_code ? min_q : top_now[31:0];
				result_q.min_value <= min_q;
			end
		end
	end

	assign result = result_q;

endmodule

// ----- bench/tb_min_tracking_stack.sv -----
// Testbench of the min tracking stack: push, pop and peek words checked against a predictor.
`timescale 1ns / 1ps

module tb_min_tracking_stack;
	import mts_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;    // unused code, acts as peek
	localparam logic signed [31:0] INT_HI = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT_LO = 32'sh8000_0000;
	localparam int QUIET_FROM = 600;           // stretch of items sent with no gaps
	localparam int QUIET_TO = 1000;
	localparam int BURST_ITEMS = 1500;         // bursts stop here, then a final drain

	// Scoreboard: predicts the word each accepted command returns and checks it.
	class min_stack_board;
		logic signed [33:0] entries [STACK_DEPTH];
		int unsigned fill;
		logic signed [31:0] low_mark;
		result_t expected [$];
		int errors, n_push, n_pop, n_peek, n_coded, n_full, n_empty, deepest;

		function new();
			fill = 0;
			low_mark = '0;
		endfunction

		// Advance the predicted stack by one command and queue the word it returns.
		function void note(item_t w);
			logic signed [33:0] x, mn, e, prev;
			logic [1:0] st;
			result_t r;
			x = {{2{w.push_value[31]}}, w.push_value};
			mn = {{2{low_mark[31]}}, low_mark};
			st = ST_OK;
			case (w.operation)
				OP_PUSH: begin
					n_push++;
					if (fill >= STACK_DEPTH) begin
						st = ST_FULL;
					end else begin
						if (fill != 0 && x < mn) begin
							// new minimum: store the code 2*value - old minimum
							entries[fill] = x + x - mn;
							low_mark = w.push_value;
							n_coded++;
						end else begin
							entries[fill] = x;
							if (fill == 0)
								low_mark = w.push_value;
						end
						fill++;
					end
				end
				OP_POP: begin
					n_pop++;
					if (fill == 0) begin
						st = ST_EMPTY;
					end else begin
						fill--;
						e = entries[fill];
						if (e < mn) begin
							// a code below the minimum: restore the previous minimum
							prev = mn + mn - e;
							low_mark = prev[31:0];
						end
					end
				end
				default: begin
					// peek and the spare code leave the stack alone
					n_peek++;
					if (fill == 0)
						st = ST_EMPTY;
				end
			endcase
			if (st == ST_FULL)
				n_full++;
			if (st == ST_EMPTY)
				n_empty++;
			if (int'(fill) > deepest)
				deepest = int'(fill);
			r.status = st;
			if (fill == 0) begin
				r.top_value = EMPTY_TOP;
				r.min_value = '0;
				r.is_empty = 1'b1;
			end else begin
				e = entries[fill - 1];
				mn = {{2{low_mark[31]}}, low_mark};
				r.top_value = (e < mn) ? low_mark : e[31:0];
				r.min_value = low_mark;
				r.is_empty = 1'b0;
			end
			expected.push_back(r);
		endfunction

		// Compare a result word with the oldest prediction, field by field.
		function void check(result_t got);
			result_t want;
			if (expected.size() == 0) begin
				$error("result word with none expected: top_value %0d", got.top_value);
				errors++;
				return;
			end
			want = expected.pop_front();
			if (got.top_value !== want.top_value) begin
				$error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
				errors++;
			end
			if (got.min_value !== want.min_value) begin
				$error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
				errors++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	item_t item = '0;
	logic busy;
	logic done;
	result_t result;

	min_stack_board board = new();
	logic signed [31:0] last_pushed = '0;
	int n_items = 0;

	always #1 clk = ~clk;

	min_tracking_stack uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	// Sample at the rising edge: the block's outputs still hold their pre-edge
	// values here, and start/item were set at the falling edge before.
	// Check the done word first so a stray result never consumes a fresh prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check(result);
			if (start && !busy)
				board.note(item);
		end
	end

	// Present one command word and hold it until the block takes it. Start stays
	// high on return, so a following word goes out back to back.
	task automatic send_word(input logic [1:0] op, input logic signed [31:0] v);
		@(negedge clk);
		start <= 1'b1;
		item <= '{operation: op, push_value: v};
		do
			@(posedge clk);
		while (busy);
		n_items++;
	endtask

	// Drop start for one cycle in which the block could take a word, and
	// scramble the idle item bus.
	task automatic rest_cycle();
		@(negedge clk);
		while (busy)
			@(negedge clk);
		start <= 1'b0;
		item <= '{operation: 2'($urandom), push_value: $urandom};
	endtask

	// Rest before a word with 21 percent chance per try, geometric gaps, unless in the quiet stretch.
	task automatic maybe_rest(input bit calm);
		if (!calm)
			while ($urandom_range(0, 99) < 21)
				rest_cycle();
	endtask

	// Mix extremes, a narrow band around zero, falling runs (these make codes) and
	// plain random values.
	function automatic logic signed [31:0] draw_value();
		case ($urandom_range(0, 9))
			0: return INT_LO;
			1: return INT_HI;
			2: return $signed(32'($urandom_range(0, 40))) - 32'sd20;
			3: return last_pushed - $signed(32'($urandom_range(1, 1000)));
			default: return $urandom;
		endcase
	endfunction

	// Bias the operation by burst mode: 0 grows the stack, 1 shrinks it, 2 mixes.
	function automatic logic [1:0] pick_op(input int mode);
		int r;
		int push_cut, pop_cut;
		r = $urandom_range(0, 99);
		push_cut = (mode == 0) ? 80 : (mode == 1) ? 15 : 45;
		pop_cut = (mode == 0) ? 92 : 85;
		if (r < push_cut)
			return OP_PUSH;
		if (r < pop_cut)
			return OP_POP;
		if (r < 97)
			return OP_PEEK;
		return OP_SPARE;
	endfunction

	task automatic random_word(input logic [1:0] op);
		logic signed [31:0] v;
		v = draw_value();
		if (op == OP_PUSH)
			last_pushed = v;
		send_word(op, v);
	endtask

	initial begin
		item_t opening [23];
		int mode, span;

		// Directed opening: empty-stack commands, extreme values, a code built
		// from both extremes, an equal minimum, and pops back down to empty.
		opening = '{
			'{OP_PEEK, 32'sd0}, '{OP_POP, 32'sd0}, '{OP_SPARE, 32'sd0},
			'{OP_PUSH, INT_HI}, '{OP_PEEK, 32'sd0}, '{OP_PUSH, INT_LO},
			'{OP_PEEK, 32'sd0}, '{OP_PUSH, INT_LO}, '{OP_PUSH, INT_HI},
			'{OP_POP, 32'sd0}, '{OP_POP, 32'sd0}, '{OP_POP, 32'sd0},
			'{OP_SPARE, INT_LO}, '{OP_POP, INT_HI}, '{OP_POP, 32'sd0},
			'{OP_PUSH, 32'sd0}, '{OP_PUSH, -32'sd1}, '{OP_PUSH, INT_LO},
			'{OP_PUSH, INT_HI}, '{OP_POP, 32'sd0}, '{OP_POP, 32'sd0},
			'{OP_POP, 32'sd0}, '{OP_POP, 32'sd0}
		};

		// Hold reset, then release it at a falling edge.
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		rest_cycle();

		foreach (opening[i])
			send_word(opening[i].operation, opening[i].push_value);

		// Fill from empty to full and push past it, then drain past empty.
		repeat (STACK_DEPTH + 3) begin
			maybe_rest(1'b0);
			random_word(OP_PUSH);
		end
		repeat (STACK_DEPTH + 2) begin
			maybe_rest(1'b0);
			random_word(OP_POP);
		end

		// Random bursts, each with its own bias, with one stretch sent gap-free.
		while (n_items < BURST_ITEMS) begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(10, 60);
			repeat (span) begin
				maybe_rest(n_items >= QUIET_FROM && n_items < QUIET_TO);
				random_word(pick_op(mode));
			end
		end

		// Drain whatever depth the bursts left, ending on pops of an empty stack.
		repeat (STACK_DEPTH + 2) begin
			maybe_rest(1'b0);
			random_word(OP_POP);
		end
		rest_cycle();

		// Wait out every pending result, then keep watching for stray strobes.
		while (board.expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d words: %0d pushes (%0d coded as new minimum), %0d pops, %0d peeks",
			n_items, board.n_push, board.n_coded, board.n_pop, board.n_peek);
		$display("%0d pushes refused on a full stack, %0d commands on empty, deepest %0d",
			board.n_full, board.n_empty, board.deepest);
		if (board.errors == 0)
			$display("tb_min_tracking_stack: clean");
		else
			$display("tb_min_tracking_stack: errors");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#200000;
		$display("tb_min_tracking_stack: errors");
		$finish;
	end

endmodule
